/* rtl/atm_pkg.sv */
// ----------------------------------------------------------------------------
// atm_pkg
// Shared constants and the arctangent table for the tilt and magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package atm_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int ANG_W        = 25;
  localparam int MAG_W        = 18;
  localparam int TILT_W       = 15;

  localparam logic [MAG_W-1:0] MAG_SCALE    = 18'd261993;
  localparam logic [MAG_W-1:0] MAG_MAX      = 18'd262143;
  localparam logic [MAG_W-1:0] THRESH_RESET = 18'd32768;
  localparam logic [22:0]      DEG90_Q16    = 23'd5898240;
  localparam logic [TILT_W-1:0] TILT_MAX    = 15'd32767;

  // atan(2^-i) in degrees, Q16
  function automatic logic [22:0] atan_q16(input int i);
    logic [22:0] a;
    case (i)
      0:  a = 23'd2949120;
      1:  a = 23'd1740967;
      2:  a = 23'd919879;
      3:  a = 23'd466945;
      4:  a = 23'd234379;
      5:  a = 23'd117304;
      6:  a = 23'd58666;
      7:  a = 23'd29335;
      8:  a = 23'd14668;
      9:  a = 23'd7334;
      10: a = 23'd3667;
      11: a = 23'd1833;
      12: a = 23'd917;
      13: a = 23'd458;
      14: a = 23'd229;
      15: a = 23'd115;
      16: a = 23'd57;
      17: a = 23'd29;
      18: a = 23'd14;
      19: a = 23'd7;
      default: a = 23'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/accel_tilt_and_magnitude.sv */
// ----------------------------------------------------------------------------
// accel_tilt_and_magnitude
// Vector magnitude, freefall flag and tilt from vertical for one 3-axis sample.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_stall carries accel_x/y/z, one request per cycle while in_stall is low
//   output channel out_valid/out_stall carries magnitude, tilt and freefall
//   cfg_wr_en/cfg_wr_data load the freefall threshold (write only while idle)
// The pipeline has one squaring stage, one sum stage, SAMPLE_BITS + 8 square
// root stages (one result bit per stage), two scaling stages, 20 CORDIC stages
// and the output register.
// Throughput is one sample per cycle while no result is stalled; every
// stage is a register with a valid bit, and the whole pipeline advances together.
// When the receiver stalls a waiting result, the pipeline freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset clears every valid bit and loads the threshold with 0.5 g.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_and_magnitude #(
  parameter int SAMPLE_BITS    = 16,
  parameter int TILT_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [17:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_accel_x,
  input  wire logic [15:0] in_accel_y,
  input  wire logic [15:0] in_accel_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [17:0]      out_magnitude,
  output logic [14:0]      out_tilt,
  output logic             out_freefall
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SQ_W  = 2 * SB;
  localparam int RW    = SB + 8;
  localparam int VW    = 2 * RW;
  localparam int REM_W = RW + 2;
  localparam int CW    = SB + 11;
  localparam int PW    = RW + atm_pkg::MAG_W + 1;
  localparam int MGW   = PW - 24;
  localparam int NS    = atm_pkg::CORDIC_STEPS;
  localparam int AW    = atm_pkg::ANG_W;
  localparam logic [23:0] TILT_LIM = 24'(90 << TILT_FRAC_BITS);
  localparam logic [23:0] ROUND_HALF = 24'(1 << (15 - TILT_FRAC_BITS));

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [17:0] thresh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= atm_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // stage 1: squares
  logic signed [SB-1:0] sx, sy, sz;
  logic [SB-1:0] az_nxt;
  logic signed [SQ_W-1:0] px, py, pz;
  assign sx = $signed(in_accel_x[SB-1:0]);
  assign sy = $signed(in_accel_y[SB-1:0]);
  assign sz = $signed(in_accel_z[SB-1:0]);
  assign px = sx * sx;
  assign py = sy * sy;
  assign pz = sz * sz;
  assign az_nxt = sz[SB-1] ? (~$unsigned(sz) + 1'b1) : $unsigned(sz);

  logic v1_r;
  logic [SQ_W-1:0] xx_r, yy_r, zz_r;
  logic [SB-1:0] az1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      xx_r  <= $unsigned(px);
      yy_r  <= $unsigned(py);
      zz_r  <= $unsigned(pz);
      az1_r <= az_nxt;
    end
  end

  // stage 2: sums
  logic [SQ_W-1:0] hsq_nxt, s_nxt;
  assign hsq_nxt = xx_r + yy_r;
  assign s_nxt   = hsq_nxt + zz_r;

  // square root pipelines, index 0 is the stage 2 register
  logic            sv_r   [0:RW];
  logic [VW-1:0]   sval_r [0:RW];
  logic [VW-1:0]   hval_r [0:RW];
  logic [REM_W-1:0] srem_r [0:RW];
  logic [REM_W-1:0] hrem_r [0:RW];
  logic [RW-1:0]   sroot_r[0:RW];
  logic [RW-1:0]   hroot_r[0:RW];
  logic [SB-1:0]   saz_r  [0:RW];
  logic            snz_r  [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sval_r[0]  <= {s_nxt, 16'd0};
      hval_r[0]  <= {hsq_nxt, 16'd0};
      srem_r[0]  <= '0;
      hrem_r[0]  <= '0;
      sroot_r[0] <= '0;
      hroot_r[0] <= '0;
      saz_r[0]   <= az1_r;
      snz_r[0]   <= |s_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_sqrt
      logic [REM_W-1:0] s_rem_sh, h_rem_sh, s_trial, h_trial;
      logic [REM_W-1:0] s_rem_nxt, h_rem_nxt;
      logic [RW-1:0]    s_root_nxt, h_root_nxt;
      always_comb begin
        s_rem_sh = {srem_r[k][RW-1:0], sval_r[k][VW-1 -: 2]};
        h_rem_sh = {hrem_r[k][RW-1:0], hval_r[k][VW-1 -: 2]};
        s_trial  = {sroot_r[k], 2'b01};
        h_trial  = {hroot_r[k], 2'b01};
        if (s_rem_sh >= s_trial) begin
          s_rem_nxt  = s_rem_sh - s_trial;
          s_root_nxt = {sroot_r[k][RW-2:0], 1'b1};
        end else begin
          s_rem_nxt  = s_rem_sh;
          s_root_nxt = {sroot_r[k][RW-2:0], 1'b0};
        end
        if (h_rem_sh >= h_trial) begin
          h_rem_nxt  = h_rem_sh - h_trial;
          h_root_nxt = {hroot_r[k][RW-2:0], 1'b1};
        end else begin
          h_rem_nxt  = h_rem_sh;
          h_root_nxt = {hroot_r[k][RW-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[k+1] <= 1'b0;
        end else if (en) begin
          sv_r[k+1] <= sv_r[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sval_r[k+1]  <= {sval_r[k][VW-3:0], 2'b00};
          hval_r[k+1]  <= {hval_r[k][VW-3:0], 2'b00};
          srem_r[k+1]  <= s_rem_nxt;
          hrem_r[k+1]  <= h_rem_nxt;
          sroot_r[k+1] <= s_root_nxt;
          hroot_r[k+1] <= h_root_nxt;
          saz_r[k+1]   <= saz_r[k];
          snz_r[k+1]   <= snz_r[k];
        end
      end
    end
  endgenerate

  // scaling stage a: product
  logic          pa_v_r;
  logic [PW-1:0] prod_r;
  logic [RW-1:0] pa_h_r;
  logic [SB-1:0] pa_az_r;
  logic          pa_nz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
    end else if (en) begin
      pa_v_r <= sv_r[RW];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= PW'(sroot_r[RW]) * PW'(atm_pkg::MAG_SCALE) + PW'(1 << 23);
      pa_h_r  <= hroot_r[RW];
      pa_az_r <= saz_r[RW];
      pa_nz_r <= snz_r[RW];
    end
  end

  // scaling stage b: magnitude and freefall
  logic [MGW-1:0] mg;
  logic [17:0]    mag_nxt;
  assign mg      = prod_r[PW-1:24];
  assign mag_nxt = (mg > atm_pkg::MAG_MAX) ? atm_pkg::MAG_MAX : 18'(mg);

  logic                 cv_r  [0:NS];
  logic signed [CW-1:0] cx_r  [0:NS];
  logic signed [CW-1:0] cy_r  [0:NS];
  logic signed [AW-1:0] cang_r[0:NS];
  logic [17:0]          cmag_r[0:NS];
  logic                 cff_r [0:NS];
  logic                 cnz_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= pa_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]   <= $signed(CW'({pa_az_r, 8'd0}));
      cy_r[0]   <= $signed(CW'(pa_h_r));
      cang_r[0] <= '0;
      cmag_r[0] <= mag_nxt;
      cff_r[0]  <= mag_nxt < thresh_r;
      cnz_r[0]  <= pa_nz_r;
    end
  end

  // cordic vectoring, one rotation per stage
  genvar j;
  generate
    for (j = 0; j < NS; j++) begin : g_cordic
      logic signed [CW-1:0] dx, dy, ny;
      logic signed [AW-1:0] da;
      assign ny = -cy_r[j];
      // negative y shifts truncate toward zero
      assign dx = cy_r[j][CW-1] ? -(ny >>> j) : (cy_r[j] >>> j);
      assign dy = cx_r[j] >>> j;
      assign da = $signed(AW'(atm_pkg::atan_q16(j)));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cv_r[j+1] <= 1'b0;
        end else if (en) begin
          cv_r[j+1] <= cv_r[j];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cy_r[j][CW-1]) begin
            cx_r[j+1]   <= cx_r[j] + dx;
            cy_r[j+1]   <= cy_r[j] - dy;
            cang_r[j+1] <= cang_r[j] + da;
          end else begin
            cx_r[j+1]   <= cx_r[j] - dx;
            cy_r[j+1]   <= cy_r[j] + dy;
            cang_r[j+1] <= cang_r[j] - da;
          end
          cmag_r[j+1] <= cmag_r[j];
          cff_r[j+1]  <= cff_r[j];
          cnz_r[j+1]  <= cnz_r[j];
        end
      end
    end
  endgenerate

  // output stage: clamp, round, saturate, and zero the tilt on freefall or a zero sum
  logic [22:0] angc;
  logic [23:0] rsum, tq;
  logic [14:0] tilt_nxt;
  always_comb begin
    if (cang_r[NS][AW-1]) begin
      angc = '0;
    end else if (cang_r[NS] > $signed(AW'(atm_pkg::DEG90_Q16))) begin
      angc = atm_pkg::DEG90_Q16;
    end else begin
      angc = cang_r[NS][22:0];
    end
    rsum = {1'b0, angc} + ROUND_HALF;
    tq   = rsum >> (16 - TILT_FRAC_BITS);
    if (tq > TILT_LIM) begin
      tq = TILT_LIM;
    end
    if (cff_r[NS] || !cnz_r[NS]) begin
      tilt_nxt = '0;
    end else if (tq > 24'(atm_pkg::TILT_MAX)) begin
      tilt_nxt = atm_pkg::TILT_MAX;
    end else begin
      tilt_nxt = tq[14:0];
    end
  end

  logic        out_valid_r;
  logic [17:0] out_magnitude_r;
  logic [14:0] out_tilt_r;
  logic        out_freefall_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv_r[NS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_magnitude_r <= cmag_r[NS];
      out_tilt_r      <= tilt_nxt;
      out_freefall_r  <= cff_r[NS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_tilt      = out_tilt_r;
  assign out_freefall  = out_freefall_r;

`ifndef SYNTHESIS
  a_ff_tilt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_freefall |-> out_tilt == '0)
    else $error("freefall result with nonzero tilt");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 24'(out_tilt) <= TILT_LIM)
    else $error("tilt above ninety degrees");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("pipeline not frozen while result waits");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid result after reset");
`endif

endmodule

`default_nettype wire
